@@ hw/rtl/fat_cluster_chain_extent_walker_unit_assert.svh @@
// Assertion helpers for the chain walker; expect clk and rst_n in scope.
`ifndef FAT_CLUSTER_CHAIN_EXTENT_WALKER_UNIT_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_EXTENT_WALKER_UNIT_ASSERT_SVH

// Hold cond at every clock edge outside reset.
`define FCCW_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fccw: invariant violated");

// Require cons in the cycle after ante.
`define FCCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fccw: sequence violated");

`endif

@@ hw/rtl/fccw_pkg.sv @@
package fccw_pkg;

    localparam int FCCW_TABLE_DEPTH          = 4096;
    localparam int FCCW_MAX_REQUEST_CLUSTERS = 64;

    localparam int IDX_W    = 12;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 7;
    localparam int SPC_W    = 8;
    localparam int SECS_W   = 14;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] MARK_MASK = 32'h0fff_ffff;
    localparam logic [WORD_W-1:0] MARK_LOW  = 32'h0fff_fff7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_WALK  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_CONT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_REGION_LBA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_LOOK,
        S_RUN,
        S_FINAL
    } walk_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] a;
        logic [SPC_W-1:0]  b;
    } mac_req_t;

    function automatic logic link_ends(input logic [WORD_W-1:0] c);
        return (c == '0) || ((c & MARK_MASK) >= MARK_LOW);
    endfunction

endpackage

@@ hw/rtl/fccw_if.sv @@
interface fccw_req_if
    import fccw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [WORD_W-1:0] entry_value;
    logic [WORD_W-1:0] start_cluster;
    logic [CNT_W-1:0]  cluster_count;

    modport source (output valid, mode, entry_index, entry_value, start_cluster,
                    cluster_count, input ready);
    modport sink   (input valid, mode, entry_index, entry_value, start_cluster,
                    cluster_count, output ready);
endinterface

interface fccw_rsp_if
    import fccw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   extent_lba;
    logic [SECS_W-1:0]   sector_count;
    logic [CNT_W-1:0]    cluster_offset;
    logic [WORD_W-1:0]   next_cluster;
    logic [STATUS_W-1:0] chain_status;
    logic                last;

    modport source (output valid, extent_lba, sector_count, cluster_offset,
                    next_cluster, chain_status, last, input ready);
    modport sink   (input valid, extent_lba, sector_count, cluster_offset,
                    next_cluster, chain_status, last, output ready);
endinterface

interface fccw_cfg_if
    import fccw_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/fccw_fat_ram.sv @@
module fccw_fat_ram
    import fccw_pkg::*;
#(
    parameter int DEPTH = FCCW_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/fccw_mac.sv @@
module fccw_mac
    import fccw_pkg::*;
(
    input  mac_req_t          req,
    output logic [WORD_W-1:0] y
);

    logic [WORD_W-1:0] b_ext;

    // Multiply-add, wrapping at the word width.
    assign b_ext = {{(WORD_W-SPC_W){1'b0}}, req.b};
    assign y     = req.acc + req.a * b_ext;

endmodule

@@ hw/rtl/fat_cluster_chain_extent_walker_unit.sv @@
// FAT32 cluster chain walker with an on-chip allocation table.
// Channels: req (sink) takes items; mode 0 writes one table entry at
// entry_index, mode 1 walks the chain from start_cluster for up to
// cluster_count clusters. rsp (source) returns one disk read command per run
// of consecutive clusters; last marks the final beat of a walk. cfg (sink)
// writes data_region_lba (index 0) and the cluster size in sectors (index 1);
// it is always ready and is meant to be written while the walker is idle.
// Operation: a table write happens on the accepting beat. During a walk the
// walker reads one table entry per cycle through the single read port while
// a run of consecutive clusters continues; at the start of each extent (state
// S_LOOK) the shared multiply-add unit forms its LBA while the previous extent is
// handed over to the output register. req.ready is low for the whole walk.
// Results leave through an output register; a stalled receiver holds the
// current beat and the walker then waits before it emits the next one.
// Reset clears the walker state, the output valid and the registers
// (data_region_lba 0, cluster size 1). The table is not cleared:
// entries must be written before a walk reaches them.
module fat_cluster_chain_extent_walker_unit
    import fccw_pkg::*;
#(
    parameter int TABLE_DEPTH          = FCCW_TABLE_DEPTH,
    parameter int MAX_REQUEST_CLUSTERS = FCCW_MAX_REQUEST_CLUSTERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    fccw_req_if.sink    req,
    fccw_rsp_if.source  rsp,
    fccw_cfg_if.sink    cfg
);

    `include "fat_cluster_chain_extent_walker_unit_assert.svh"

    localparam int                AW      = $clog2(TABLE_DEPTH);
    localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_REQUEST_CLUSTERS);

    // configuration registers
    logic [WORD_W-1:0] lba_base_reg;
    logic [SPC_W-1:0]  spc_reg;

    // walk state
    walk_state_t         state_reg, state_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    off_reg, off_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [WORD_W-1:0]   lba_reg, lba_next;

    // extent waiting to learn whether it is the last one
    logic                pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0]   pend_lba_reg, pend_lba_next;
    logic [SECS_W-1:0]   pend_secs_reg, pend_secs_next;
    logic [CNT_W-1:0]    pend_off_reg, pend_off_next;
    logic [WORD_W-1:0]   pend_next_reg, pend_next_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_lba_reg;
    logic [SECS_W-1:0]   out_secs_reg;
    logic [CNT_W-1:0]    out_off_reg;
    logic [WORD_W-1:0]   out_next_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                push;
    logic                push_last;

    logic                ram_we;
    logic [WORD_W-1:0]   wr_idx;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]   ram_q;

    mac_req_t            mac_req;
    logic [WORD_W-1:0]   mac_y;

    logic [CNT_W-1:0]    n_inc;
    logic [CNT_W-1:0]    rem_left;
    logic                run_close;

    fccw_fat_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (req.entry_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    fccw_mac u_mac (
        .req (mac_req),
        .y   (mac_y)
    );

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_base_reg <= '0;
            spc_reg      <= SPC_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_DATA_REGION_LBA: lba_base_reg <= cfg.data;
                REG_CLUSTER_SECTORS: spc_reg      <= cfg.data[SPC_W-1:0];
            endcase
        end
    end

    // table writes happen on the accepting beat; drop indexes past the table
    assign req.ready = (state_reg == S_IDLE);
    assign wr_idx    = WORD_W'(req.entry_index);
    assign ram_we    = req.valid && req.ready && (req.mode == MODE_WRITE)
                       && (wr_idx < DEPTH_W);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign n_inc     = n_reg + CNT_W'(1);
    assign rem_left  = rem_reg - n_inc;
    assign run_close = (n_inc == rem_reg) || (ram_q != cur_reg + WORD_W'(1));

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        rem_next         = rem_reg;
        off_next         = off_reg;
        n_next           = n_reg;
        lba_next         = lba_reg;
        pend_valid_next  = pend_valid_reg;
        pend_lba_next    = pend_lba_reg;
        pend_secs_next   = pend_secs_reg;
        pend_off_next    = pend_off_reg;
        pend_next_next   = pend_next_reg;
        pend_status_next = pend_status_reg;
        push             = 1'b0;
        push_last        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = cur_reg[AW-1:0];
        // default use of the shared unit: sectors of the run so far
        mac_req          = '{acc: '0, a: WORD_W'(n_inc), b: spc_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.mode == MODE_WALK)
                begin
                    cur_next        = req.start_cluster;
                    rem_next        = (req.cluster_count > MAX_CNT) ? MAX_CNT
                                                                   : req.cluster_count;
                    off_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_START;
                end
            end

            S_START:
            begin
                if (rem_reg == '0 || link_ends(cur_reg))
                begin
                    // nothing to read: one empty beat
                    pend_lba_next    = '0;
                    pend_secs_next   = '0;
                    pend_off_next    = '0;
                    pend_next_next   = cur_reg;
                    pend_status_next = (rem_reg == '0) ? ST_CONT : ST_END;
                    pend_valid_next  = 1'b1;
                    state_next       = S_FINAL;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                // start of a run: the shared unit forms its LBA
                mac_req = '{acc: lba_base_reg, a: cur_reg - WORD_W'(2), b: spc_reg};
                if (cur_reg >= DEPTH_W)
                begin
                    // off the table with an empty run: mark the previous
                    // extent, or emit an empty one if there is none
                    if (!pend_valid_reg)
                    begin
                        pend_lba_next  = '0;
                        pend_secs_next = '0;
                        pend_off_next  = off_reg;
                        pend_next_next = cur_reg;
                    end
                    pend_status_next = ST_OOR;
                    pend_valid_next  = 1'b1;
                    state_next       = S_FINAL;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = cur_reg[AW-1:0];
                    lba_next        = mac_y;
                    n_next          = '0;
                    state_next      = S_RUN;
                end
            end

            S_RUN:
            begin
                if (run_close)
                begin
                    pend_lba_next    = lba_reg;
                    pend_secs_next   = mac_y[SECS_W-1:0];
                    pend_off_next    = off_reg;
                    pend_next_next   = ram_q;
                    pend_status_next = (rem_left != '0 && link_ends(ram_q)) ? ST_END
                                                                           : ST_CONT;
                    pend_valid_next  = 1'b1;
                    rem_next         = rem_left;
                    off_next         = off_reg + n_inc;
                    cur_next         = ram_q;
                    state_next       = (rem_left == '0 || link_ends(ram_q)) ? S_FINAL
                                                                           : S_LOOK;
                end
                else if (ram_q >= DEPTH_W)
                begin
                    // link leaves the table mid-run: close with out-of-range
                    pend_lba_next    = lba_reg;
                    pend_secs_next   = mac_y[SECS_W-1:0];
                    pend_off_next    = off_reg;
                    pend_next_next   = ram_q;
                    pend_status_next = ST_OOR;
                    pend_valid_next  = 1'b1;
                    state_next       = S_FINAL;
                end
                else
                begin
                    // consecutive link: advance, read the next entry
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ram_q[AW-1:0];
                    cur_next    = ram_q;
                    n_next      = n_inc;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        rem_reg         <= rem_next;
        off_reg         <= off_next;
        n_reg           <= n_next;
        lba_reg         <= lba_next;
        pend_lba_reg    <= pend_lba_next;
        pend_secs_reg   <= pend_secs_next;
        pend_off_reg    <= pend_off_next;
        pend_next_reg   <= pend_next_next;
        pend_status_reg <= pend_status_next;
        if (push)
        begin
            out_lba_reg    <= pend_lba_reg;
            out_secs_reg   <= pend_secs_reg;
            out_off_reg    <= pend_off_reg;
            out_next_reg   <= pend_next_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= push_last;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.extent_lba     = out_lba_reg;
    assign rsp.sector_count   = out_secs_reg;
    assign rsp.cluster_offset = out_off_reg;
    assign rsp.next_cluster   = out_next_reg;
    assign rsp.chain_status   = out_status_reg;
    assign rsp.last           = out_last_reg;

    // a run never counts past what is left of the request
    `FCCW_ASSERT_ALWAYS(a_run_within_rem, (state_reg != S_RUN) || (n_reg < rem_reg))
    // a beat is only handed over when the output register can take it
    `FCCW_ASSERT_ALWAYS(a_push_needs_room, !push || out_free)
    // a new run only starts with clusters left to cover
    `FCCW_ASSERT_ALWAYS(a_look_has_work, (state_reg != S_LOOK) || (rem_reg != '0))
    // an accepted walk moves the sequencer out of idle
    `FCCW_ASSERT_NEXT(a_walk_starts, req.valid && req.ready && req.mode == MODE_WALK,
                      state_reg == S_START)

endmodule
